FILE: sv/rma_pkg.sv
package rma_pkg;

  // item actions
  typedef enum logic [1:0] {
    ACT_ROT_X = 2'd0,
    ACT_ROT_Y = 2'd1,
    ACT_ROT_Z = 2'd2,
    ACT_LOAD  = 2'd3
  } act_e;

  // matrix entries, three vectors of three components
  localparam int unsigned NUM_ENTRIES = 9;
  localparam int unsigned IDX_WIDTH   = 4;

  // pi/2 in unsigned Q60
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1847;

  // taylor series divisors (2n)*(2n+1) for the sine table build
  localparam logic [63:0] TAYLOR_DIV [1:23] = '{
    64'd6,    64'd20,   64'd42,   64'd72,   64'd110,  64'd156,  64'd210,  64'd272,
    64'd342,  64'd420,  64'd506,  64'd600,  64'd702,  64'd812,  64'd930,  64'd1056,
    64'd1190, 64'd1332, 64'd1482, 64'd1640, 64'd1806, 64'd1980, 64'd2162
  };

endpackage

FILE: sv/rotation_matrix_accumulator.sv
// rotation matrix accumulator
// keeps a 3x3 orientation matrix (three basis vectors, fixed point with two
// integer bits) and either loads one entry or rotates all three vectors about
// the x, y or z axis by an angle given as a fraction of a full turn.
// input channel: in_valid_i / in_stall_o with action, angle, entry index and
// value; a beat is taken at a rising edge with valid high and stall low.
// output channel: out_valid_o / out_stall_i carrying all nine entries of the
// matrix as it stands after the item.
// throughput: one item per cycle while the result is not stalled. sine and cosine
// are looked up from the quarter-wave table as the beat is taken and held in the
// input register; from there twelve parallel multipliers with rounding and a
// saturating add update the matrix register. each item passes the input register
// and then the matrix register before it shows as a result.
// a stalled result holds: the matrix register is the output register and only
// changes when that result is taken; the input stalls while an item also
// waits in the input register behind the stalled result.
// reset: the matrix returns to identity and both stages empty.
module rotation_matrix_accumulator
  import rma_pkg::*;
#(
  parameter int unsigned ENTRY_WIDTH      = 16,
  parameter int unsigned ANGLE_WIDTH      = 16,
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [ANGLE_WIDTH-1:0]        angle_i,
  input  logic [IDX_WIDTH-1:0]          entry_index_i,
  input  logic signed [ENTRY_WIDTH-1:0] entry_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [ENTRY_WIDTH-1:0] xvec_x_o,
  output logic signed [ENTRY_WIDTH-1:0] xvec_y_o,
  output logic signed [ENTRY_WIDTH-1:0] xvec_z_o,
  output logic signed [ENTRY_WIDTH-1:0] yvec_x_o,
  output logic signed [ENTRY_WIDTH-1:0] yvec_y_o,
  output logic signed [ENTRY_WIDTH-1:0] yvec_z_o,
  output logic signed [ENTRY_WIDTH-1:0] zvec_x_o,
  output logic signed [ENTRY_WIDTH-1:0] zvec_y_o,
  output logic signed [ENTRY_WIDTH-1:0] zvec_z_o
);

  localparam int unsigned FB = ENTRY_WIDTH - 2;
  localparam int unsigned PW = 2 * ENTRY_WIDTH;
  localparam int unsigned RW = ENTRY_WIDTH + 2;
  localparam int unsigned SW = ENTRY_WIDTH + 3;
  localparam int unsigned TW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned AR = ANGLE_WIDTH - 2;
  localparam int unsigned MW = AR + TW;

  localparam logic [MW-1:0] DEPTH_M = MW'(SINE_TABLE_DEPTH);
  localparam logic [TW-1:0] DEPTH_T = TW'(SINE_TABLE_DEPTH);
  localparam logic signed [PW-1:0] HALF_LSB = PW'(1) << (FB - 1);
  localparam logic signed [SW-1:0] SAT_MAX = (SW'(1) << (ENTRY_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;
  localparam logic signed [ENTRY_WIDTH-1:0] ONE_ENT = ENTRY_WIDTH'(1) << FB;

  typedef logic signed [ENTRY_WIDTH-1:0] ent_t;

  // unsigned Q60 multiply, operands below 2^62
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // sin(pi/2 * k / depth) rounded to FB fraction bits, evaluated at elaboration
  function automatic logic [63:0] quarter_sine(input int unsigned k);
    logic [63:0] kk;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    kk   = 64'(k);
    x    = (HALF_PI_Q60 / SINE_TABLE_DEPTH) * kk
         + ((HALF_PI_Q60 % SINE_TABLE_DEPTH) * kk) / SINE_TABLE_DEPTH;
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n < 24; n++) begin
      if (term != 64'd0) begin
        term = mul_q60(term, x2) / TAYLOR_DIV[n];
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return (sum + (64'd1 << (59 - FB))) >> (60 - FB);
  endfunction

  // product rounded to nearest, ties up, back to FB fraction bits
  function automatic logic signed [RW-1:0] rnd_prod(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] b;
    b = (p + HALF_LSB) >>> FB;
    return b[RW-1:0];
  endfunction

  // clamp to the signed entry range
  function automatic ent_t sat_ent(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] y;
    y = x;
    if (x > SAT_MAX) begin
      y = SAT_MAX;
    end else if (x < SAT_MIN) begin
      y = SAT_MIN;
    end
    return y[ENTRY_WIDTH-1:0];
  endfunction

  // quarter-wave sine table
  logic [ENTRY_WIDTH-1:0] sine_tab [SINE_TABLE_DEPTH+1];

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_sine
    assign sine_tab[g] = ENTRY_WIDTH'(quarter_sine(g));
  end

  // handshake control
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic s1_adv;
  logic in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // sine and cosine of the incoming angle
  logic [1:0]    quad;
  logic [AR-1:0] rem;
  logic [MW-1:0] kprod;
  logic [TW-1:0] k_idx;
  logic [TW-1:0] k_inv;
  ent_t          t0;
  ent_t          t1;
  ent_t          sin_d;
  ent_t          cos_d;

  always_comb begin
    quad  = angle_i[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
    rem   = angle_i[AR-1:0];
    kprod = MW'(rem) * DEPTH_M;
    k_idx = TW'(kprod >> AR);
    k_inv = DEPTH_T - k_idx;
    t0    = sine_tab[k_idx];
    t1    = sine_tab[k_inv];
    unique case (quad)
      2'd0: begin
        sin_d = t0;
        cos_d = t1;
      end
      2'd1: begin
        sin_d = t1;
        cos_d = -t0;
      end
      2'd2: begin
        sin_d = -t0;
        cos_d = -t1;
      end
      default: begin
        sin_d = -t1;
        cos_d = t0;
      end
    endcase
  end

  // input register
  act_e                 s1_act_q;
  ent_t                 s1_sin_q;
  ent_t                 s1_cos_q;
  logic [IDX_WIDTH-1:0] s1_idx_q;
  ent_t                 s1_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_act_q <= ACT_LOAD;
      s1_sin_q <= '0;
      s1_cos_q <= '0;
      s1_idx_q <= '0;
      s1_val_q <= '0;
    end else if (in_take) begin
      s1_act_q <= act_e'(action_i);
      s1_sin_q <= sin_d;
      s1_cos_q <= cos_d;
      s1_idx_q <= entry_index_i;
      s1_val_q <= entry_value_i;
    end
  end

  // matrix update: three vector lanes, four products each
  ent_t mat_q [NUM_ENTRIES];
  ent_t mat_d [NUM_ENTRIES];
  ent_t lane_u [3];
  ent_t lane_v [3];
  ent_t new_u [3];
  ent_t new_v [3];

  always_comb begin
    logic signed [RW-1:0] uc;
    logic signed [RW-1:0] vs;
    logic signed [RW-1:0] us;
    logic signed [RW-1:0] vc;
    for (int i = 0; i < 3; i++) begin
      unique case (s1_act_q)
        ACT_ROT_X: begin
          lane_u[i] = mat_q[3*i+1];
          lane_v[i] = mat_q[3*i+2];
        end
        ACT_ROT_Y: begin
          lane_u[i] = mat_q[3*i+2];
          lane_v[i] = mat_q[3*i];
        end
        ACT_ROT_Z: begin
          lane_u[i] = mat_q[3*i];
          lane_v[i] = mat_q[3*i+1];
        end
        ACT_LOAD: begin
          lane_u[i] = '0;
          lane_v[i] = '0;
        end
      endcase
      uc = rnd_prod(PW'(lane_u[i]) * PW'(s1_cos_q));
      vs = rnd_prod(PW'(lane_v[i]) * PW'(s1_sin_q));
      us = rnd_prod(PW'(lane_u[i]) * PW'(s1_sin_q));
      vc = rnd_prod(PW'(lane_v[i]) * PW'(s1_cos_q));
      new_u[i] = sat_ent(SW'(uc) - SW'(vs));
      new_v[i] = sat_ent(SW'(us) + SW'(vc));
    end

    mat_d = mat_q;
    for (int i = 0; i < 3; i++) begin
      unique case (s1_act_q)
        ACT_ROT_X: begin
          mat_d[3*i+1] = new_u[i];
          mat_d[3*i+2] = new_v[i];
        end
        ACT_ROT_Y: begin
          mat_d[3*i+2] = new_u[i];
          mat_d[3*i]   = new_v[i];
        end
        ACT_ROT_Z: begin
          mat_d[3*i]   = new_u[i];
          mat_d[3*i+1] = new_v[i];
        end
        ACT_LOAD: begin
          for (int j = 0; j < 3; j++) begin
            if (s1_idx_q == IDX_WIDTH'(3*i+j)) begin
              mat_d[3*i+j] = s1_val_q;
            end
          end
        end
      endcase
    end
  end

  // matrix register, also the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        mat_q[i] <= (i % 4 == 0) ? ONE_ENT : '0;
      end
    end else if (s1_adv) begin
      mat_q <= mat_d;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result beat
  assign out_valid_o = out_valid_q;
  assign xvec_x_o    = mat_q[0];
  assign xvec_y_o    = mat_q[1];
  assign xvec_z_o    = mat_q[2];
  assign yvec_x_o    = mat_q[3];
  assign yvec_y_o    = mat_q[4];
  assign yvec_z_o    = mat_q[5];
  assign zvec_x_o    = mat_q[6];
  assign zvec_y_o    = mat_q[7];
  assign zvec_z_o    = mat_q[8];

`ifndef ASSERT_OFF
  // input only stalls behind a full stage and a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // an advancing item always shows up as a result
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("advanced item produced no result");

  // a stalled result keeps the whole matrix
  a_hold_matrix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(xvec_x_o) && $stable(xvec_y_o) && $stable(xvec_z_o) &&
       $stable(yvec_x_o) && $stable(yvec_y_o) && $stable(yvec_z_o) &&
       $stable(zvec_x_o) && $stable(zvec_y_o) && $stable(zvec_z_o)))
    else $error("matrix changed under a stalled result");
`endif

endmodule
